// ===== design/periodic_task_timer_table_assert.svh =====
// Assertion macros used by the timer table back end (ptt_back).
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ptt_pkg.sv =====
`timescale 1ns / 1ps
package ptt_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic        repeat_req;
    logic [31:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_id;
    logic       status;
    logic [4:0] active_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic [31:0] count;
    logic        periodic;
  } slot_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic        is_tick;
    logic        skip;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic        repeat_req;
    logic [31:0] elapsed;
  } cmd_t;

endpackage

// ===== design/ptt_front.sv =====
`timescale 1ns / 1ps
module ptt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  ptt_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output ptt_pkg::cmd_t     cmd
);
  import ptt_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              wr, rd;
  cmd_t              c;

  always_comb begin
    c.is_tick    = in_data.req_type == REQ_TICK;
    c.skip       = (in_data.req_type == REQ_TICK) && (in_data.elapsed == 32'd0);
    c.task_id    = in_data.task_id;
    c.interval   = in_data.interval;
    c.repeat_req = in_data.repeat_req;
    c.elapsed    = in_data.elapsed;
  end

  assign in_full   = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign cmd_valid = cnt_r != '0;
  assign cmd       = q_r[rp_r];
  assign wr        = in_push && !in_full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
  end

endmodule

// ===== design/ptt_back.sv =====
`timescale 1ns / 1ps
module ptt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  ptt_pkg::cmd_t      cmd,
  output logic               out_empty,
  input  logic               out_pop,
  output ptt_pkg::out_item_t out_data
);
  import ptt_pkg::*;
  `include "periodic_task_timer_table_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           st_r, st_nxt;
  slot_t            slot_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] i_r;
  logic [31:0]      el_r;
  out_item_t        hold_r;
  logic             hold_v_r;
  out_item_t        ob_r;
  logic             ob_v_r;

  out_item_t        ob_nxt;
  logic             ob_load;
  logic             ob_free;
  logic             is_full, do_add, do_step, do_drop, at_end;
  logic [32:0]      sum;
  logic [31:0]      newc;
  logic             fire;
  slot_t            cur;
  out_item_t        fire_item;

  assign ob_free   = !ob_v_r || out_pop;
  assign out_empty = !ob_v_r;
  assign out_data  = ob_r;
  assign cmd_take  = (st_r == S_IDLE) && cmd_valid && ob_free;

  assign is_full = n_r == CNT_W'(SLOTS);
  assign do_add  = cmd_take && !cmd.is_tick && !is_full;

  assign cur    = slot_r[i_r];
  assign sum    = {1'b0, cur.count} + {1'b0, el_r};
  assign newc   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign fire   = newc >= cur.interval;
  assign at_end = i_r == IDX_W'(SLOTS - 1);
  // a second firing entry waits until the held result can move on
  assign do_step = (st_r == S_WALK) && valid_r[i_r] && (!fire || !hold_v_r || ob_free);
  assign do_drop = do_step && fire && !cur.periodic;

  always_comb begin
    fire_item              = '0;
    fire_item.kind         = KIND_FIRED;
    fire_item.fired_id     = cur.task_id;
    fire_item.active_count = do_drop ? 5'(n_r - 1'b1) : 5'(n_r);
  end

  always_comb begin
    ob_load     = 1'b0;
    ob_nxt      = '0;
    ob_nxt.last = 1'b1;
    unique case (st_r)
      S_IDLE: begin
        if (cmd_take && !(cmd.is_tick && !cmd.skip)) begin
          ob_load = 1'b1;
          if (!cmd.is_tick) begin
            ob_nxt.kind         = KIND_ADD;
            ob_nxt.status       = is_full;
            ob_nxt.active_count = is_full ? 5'(n_r) : 5'(n_r + 1'b1);
          end else begin
            ob_nxt.kind         = KIND_NONE;
            ob_nxt.active_count = 5'(n_r);
          end
        end
      end
      S_WALK: begin
        if (do_step && fire && hold_v_r) begin
          ob_load = 1'b1;
          ob_nxt  = hold_r;
        end
      end
      S_EMIT: begin
        if (ob_free) begin
          ob_load = 1'b1;
          if (hold_v_r) begin
            ob_nxt      = hold_r;
            ob_nxt.last = 1'b1;
          end else begin
            ob_nxt.kind         = KIND_NONE;
            ob_nxt.active_count = 5'(n_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (cmd_take && cmd.is_tick && !cmd.skip) st_nxt = S_WALK;
      S_WALK: if (!valid_r[i_r] || (do_step && at_end && !do_drop)) st_nxt = S_EMIT;
      S_EMIT: if (ob_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      valid_r  <= '0;
      n_r      <= '0;
      i_r      <= '0;
      el_r     <= '0;
      hold_v_r <= 1'b0;
      ob_v_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ob_v_r <= ob_load || (ob_v_r && !out_pop);
      if (do_add) begin
        valid_r <= (valid_r << 1) | SLOTS'(1);
        n_r     <= n_r + 1'b1;
      end else if (do_drop) begin
        valid_r <= valid_r >> 1;
        n_r     <= n_r - 1'b1;
      end
      if (cmd_take && cmd.is_tick) begin
        i_r  <= '0;
        el_r <= cmd.elapsed;
      end else if (do_step && (!fire || cur.periodic) && !at_end) begin
        i_r <= i_r + 1'b1;
      end
      if (do_step && fire) begin
        hold_v_r <= 1'b1;
      end else if (st_r == S_EMIT && ob_free) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) ob_r <= ob_nxt;
    if (do_step && fire) hold_r <= fire_item;
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      for (int j = SLOTS - 1; j > 0; j--) slot_r[j] <= slot_r[j-1];
      slot_r[0] <= '{task_id: cmd.task_id, interval: cmd.interval,
                     count: 32'd0, periodic: cmd.repeat_req};
    end else if (do_drop) begin
      for (int j = 0; j < SLOTS - 1; j++) begin
        if (IDX_W'(j) >= i_r) slot_r[j] <= slot_r[j+1];
      end
    end else if (do_step) begin
      slot_r[i_r].count <= fire ? 32'd0 : newc;
    end
  end

  `PTT_ASSERT_IMP(a_cnt_match, 1'b1, n_r == CNT_W'($countones(valid_r)))
  `PTT_ASSERT_IMP(a_take_idle, cmd_take, st_r == S_IDLE)
  `PTT_ASSERT_IMP(a_prefix, 1'b1, ((valid_r + 1'b1) & valid_r) == '0)
  `PTT_ASSERT_NXT(a_ob_hold, ob_v_r && !out_pop, ob_v_r && $stable(ob_r))

endmodule

// ===== design/periodic_task_timer_table.sv =====
`timescale 1ns / 1ps
// Periodic and one-shot task timer table, up to 16 entries, newest first.
// Input channel: in_push / in_full carry one request (add or tick) per transfer.
// Result channel: out_empty / out_pop; each request gives one or more results,
// the final one flagged by last.
// An add answers ok or full. A tick walks the active entries one per cycle,
// pausing while a firing entry waits for the output; each firing entry yields
// one result, otherwise one nothing-fired result. An add or zero-elapsed tick
// passes through the input queue and is then registered in the result buffer.
// A fired result is held until the next entry fires or the walk ends, so that
// it can carry last.
// Throughput: one add per cycle while the receiver keeps popping; a tick
// occupies the back end until its walk and final result are done. A two-entry
// queue in front accepts further requests meanwhile.
// Reset (synchronous, rst_n low) empties the table and both queues.
// When the receiver holds off pop, the walk pauses at a firing entry while an
// earlier fired result still waits; the input queue fills, then in_full rises.
module periodic_task_timer_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ptt_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output ptt_pkg::out_item_t out_data
);
  import ptt_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  ptt_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  ptt_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .out_empty, .out_pop, .out_data
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ptt_pkg::*;

  class timer_scoreboard;
    logic        valid [SLOTS];
    logic [7:0]  tid [SLOTS];
    logic [31:0] ivl [SLOTS];
    logic [31:0] cnt [SLOTS];
    logic        per [SLOTS];
    out_item_t   pending_results[$];
    int          mismatches;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] = 1'b0; tid[i] = 8'd0; ivl[i] = 32'd0; cnt[i] = 32'd0; per[i] = 1'b0;
      end
      pending_results.delete();
      mismatches = 0;
    endfunction

    function int active();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (valid[i]) n++;
      return n;
    endfunction

    function void drop_slot(int pos);
      for (int j = pos; j + 1 < SLOTS; j++) begin
        valid[j] = valid[j+1]; tid[j] = tid[j+1]; ivl[j] = ivl[j+1];
        cnt[j] = cnt[j+1]; per[j] = per[j+1];
      end
      valid[SLOTS-1] = 1'b0; tid[SLOTS-1] = 8'd0; ivl[SLOTS-1] = 32'd0;
      cnt[SLOTS-1] = 32'd0; per[SLOTS-1] = 1'b0;
    endfunction

    function void note_request(in_item_t r);
      out_item_t o;
      out_item_t batch[$];
      int n, i;
      logic [32:0] sum;
      n = active();
      if (r.req_type == REQ_ADD) begin
        o = '0;
        o.kind = KIND_ADD;
        if (n >= SLOTS) begin
          o.status = 1'b1;
          o.active_count = 5'(n);
        end else begin
          for (int j = SLOTS - 1; j > 0; j--) begin
            valid[j] = valid[j-1]; tid[j] = tid[j-1]; ivl[j] = ivl[j-1];
            cnt[j] = cnt[j-1]; per[j] = per[j-1];
          end
          valid[0] = 1'b1; tid[0] = r.task_id; ivl[0] = r.interval;
          cnt[0] = 32'd0; per[0] = r.repeat_req;
          o.active_count = 5'(n + 1);
        end
        o.last = 1'b1;
        pending_results.push_back(o);
        return;
      end
      if (r.elapsed != 0) begin
        i = 0;
        while (i < SLOTS && valid[i]) begin
          sum = {1'b0, cnt[i]} + {1'b0, r.elapsed};
          cnt[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (cnt[i] >= ivl[i]) begin
            o = '0;
            o.kind = KIND_FIRED;
            o.fired_id = tid[i];
            cnt[i] = 32'd0;
            if (!per[i]) begin
              drop_slot(i);
              n--;
            end else i++;
            o.active_count = 5'(n);
            batch.push_back(o);
          end else i++;
        end
      end
      if (batch.size() == 0) begin
        o = '0;
        o.kind = KIND_NONE;
        o.active_count = 5'(n);
        batch.push_back(o);
      end
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) pending_results.push_back(batch[k]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending_results.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 0;
  out_item_t out_data;

  timer_scoreboard sb;
  bit quiet_phase = 0;
  int idle_cycles = 0;
  int accepted_in = 0;

  always #5 clk = ~clk;

  periodic_task_timer_table uut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.note_request(in_data);
        accepted_in <= accepted_in + 1;
      end
      if (out_pop && !out_empty) sb.check_result(out_data);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts except in the quiet phase
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 6);
        out_pop <= 0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1;
      @(posedge clk);
    end
  end

  task automatic send_request(in_item_t r);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_data <= r;
    in_push <= 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_add(logic [7:0] id, logic [31:0] iv, logic rep);
    in_item_t r;
    r = '0;
    r.req_type = REQ_ADD; r.task_id = id; r.interval = iv; r.repeat_req = rep;
    r.elapsed = $urandom;
    send_request(r);
  endtask

  task automatic send_tick(logic [31:0] el);
    in_item_t r;
    r = '0;
    r.req_type = REQ_TICK; r.elapsed = el;
    r.task_id = 8'($urandom); r.interval = $urandom; r.repeat_req = 1'($urandom);
    send_request(r);
  endtask

  function automatic logic [31:0] rand_span();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    int wait_cycles;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_add(8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_add(8'h00, 32'd0, 1'b0);
    send_add(8'hA5, 32'd3, 1'b1);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd2);
    for (int i = 0; i < 15; i++) send_add(8'(i), 32'd5, i[0]);
    send_tick(32'd5);
    send_tick(32'd5);

    for (int i = 0; i < 135; i++) begin
      if (i == 110) quiet_phase = 1;
      if ($urandom_range(0, 1) == 0) send_add(8'($urandom), rand_span(), 1'($urandom));
      else send_tick(rand_span());
    end
    in_push <= 0;

    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
